/* rtl/rtp_h264_depacketizer_macros.svh */
// assertion macros shared by the depacketizer modules
`ifndef RTP_H264_DEPACKETIZER_MACROS_SVH
`define RTP_H264_DEPACKETIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RTPD_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RTPD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rtpd_pkg.sv */
// types and constants shared by the depacketizer modules
`default_nettype none

package rtpd_pkg;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_HDR,
    S_CHK_OFF,
    S_EXT_HI,
    S_EXT_LO,
    S_CHK_PLD,
    S_NAL,
    S_FU,
    S_DRAIN
  } state_t;

  // per-packet status codes
  typedef enum logic [2:0] {
    STS_READY        = 3'd0,
    STS_MALFORMED    = 3'd1,
    STS_BAD_VERSION  = 3'd2,
    STS_AGGREGATION  = 3'd3,
    STS_UNKNOWN_TYPE = 3'd4,
    STS_OVERSIZE     = 3'd5
  } status_t;

  // packet buffer read address source
  typedef enum logic [2:0] {
    RA_PTR,
    RA_NAL,
    RA_FU,
    RA_EXT_HI,
    RA_EXT_LO
  } rd_sel_t;

  // rtp header layout
  localparam int          RTP_FIXED_HDR = 12;
  localparam logic [1:0]  RTP_VERSION   = 2'd2;
  localparam int          EXT_HDR_BYTES = 4;
  localparam int          FU_HDR_BYTES  = 2;

  // nal unit types
  localparam logic [4:0]  NAL_TYPE_SINGLE_MAX = 5'd23;
  localparam logic [4:0]  NAL_TYPE_STAP_A     = 5'd24;
  localparam logic [4:0]  NAL_TYPE_FU_A       = 5'd28;

  // start code sequencer steps
  localparam logic [2:0]  PFX_NONE    = 3'd0;
  localparam logic [2:0]  PFX_FIRST   = 3'd1;
  localparam logic [2:0]  PFX_ONE     = 3'd4;
  localparam logic [2:0]  PFX_NAL_HDR = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic    wr_byte;
    logic    wr_last;
    logic    chk_hdr;
    logic    ext_hi_ld;
    logic    ext_ld;
    logic    nal_ld;
    logic    single_acc;
    logic    fu_acc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    drain_prefix;
    logic    drain_issue;
    logic    drain_emit;
    logic    drain_stop;
    logic    emit_status;
    status_t code;
  } rtpd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic    drain_pending;
    logic    prefix_nz;
    logic    rp_lt_end;
    status_t hdr_code;
    logic    off_fail;
    logic    ext_en;
    logic    ext_short;
    logic    ext_fail;
    logic    pld_empty;
    logic    nal_single;
    logic    nal_fu;
    logic    nal_agg;
    logic    fu_short;
  } rtpd_sts_t;

endpackage

`default_nettype wire

/* rtl/rtp_h264_depacketizer.sv */
// Packet byte beats: busy stays low throughout; no result unless last.
// Last byte: busy while the header and nal type are parsed from the buffer
//   ram, and the status beat is registered from the state that ends the parse.
// Drain ticks: start code bytes come from the sequencer, payload bytes via a
//   registered ram read. Results: one-cycle strobes, the receiver cannot stall.
// Reset (sync, rst_n low) clears counters, drain state and fsm; ram not cleared.
`default_nettype none

`include "rtp_h264_depacketizer_macros.svh"

module rtp_h264_depacketizer #(
  parameter int PACKET_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  output logic       out_is_status,
  output logic [2:0] out_status,
  output logic [7:0] out_out_byte,
  output logic       out_end_of_unit
);

  import rtpd_pkg::*;

  rtpd_cmd_t cmd;
  rtpd_sts_t sts;

  // sequencer
  rtpd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_cmd       (in_cmd),
    .in_last_byte (in_last_byte),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  // buffer and parse datapath
  rtpd_dp #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_is_status   (out_is_status),
    .out_status      (out_status),
    .out_out_byte    (out_out_byte),
    .out_end_of_unit (out_end_of_unit)
  );

  // assertions
  `RTPD_ASSERT_IMPLY(a_result_when_idle, clk, rst_n, out_valid, !busy,
                     "result beat while busy")
  `RTPD_ASSERT_NEXT(a_no_result_mid_packet, clk, rst_n,
                    start && !busy && !in_cmd && !in_last_byte, !out_valid,
                    "result after a mid-packet byte")

endmodule

`default_nettype wire

/* rtl/rtpd_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module rtpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rtpd_ctrl.sv */
// controller state machine for the depacketizer
`default_nettype none

`include "rtp_h264_depacketizer_macros.svh"

module rtpd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_cmd,
  input  logic                  in_last_byte,
  input  rtpd_pkg::rtpd_sts_t   sts,
  output rtpd_pkg::rtpd_cmd_t   cmd,
  output logic                  busy
);

  import rtpd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_cmd && in_last_byte) begin
          state_nxt = S_CHK_HDR;
        end else if (accept && in_cmd && sts.drain_pending && !sts.prefix_nz &&
                     sts.rp_lt_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_CHK_HDR: begin
        state_nxt = (sts.hdr_code != STS_READY) ? S_IDLE : S_CHK_OFF;
      end
      S_CHK_OFF: begin
        if (sts.off_fail) begin
          state_nxt = S_IDLE;
        end else if (sts.ext_en) begin
          state_nxt = sts.ext_short ? S_IDLE : S_EXT_HI;
        end else begin
          state_nxt = S_CHK_PLD;
        end
      end
      S_EXT_HI: begin
        state_nxt = S_EXT_LO;
      end
      S_EXT_LO: begin
        state_nxt = sts.ext_fail ? S_IDLE : S_CHK_PLD;
      end
      S_CHK_PLD: begin
        state_nxt = sts.pld_empty ? S_IDLE : S_NAL;
      end
      S_NAL: begin
        state_nxt = (sts.nal_fu && !sts.fu_short) ? S_FU : S_IDLE;
      end
      S_FU: begin
        state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RA_PTR;
    cmd.code   = STS_READY;
    busy       = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_cmd) begin
          cmd.wr_byte = 1'b1;
          cmd.wr_last = in_last_byte;
        end else if (accept && sts.drain_pending) begin
          if (sts.prefix_nz) begin
            cmd.drain_prefix = 1'b1;
          end else if (sts.rp_lt_end) begin
            cmd.drain_issue = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_sel      = RA_PTR;
          end else begin
            cmd.drain_stop = 1'b1;
          end
        end
      end
      S_CHK_HDR: begin
        if (sts.hdr_code != STS_READY) begin
          cmd.emit_status = 1'b1;
          cmd.code        = sts.hdr_code;
        end else begin
          cmd.chk_hdr = 1'b1;
        end
      end
      S_CHK_OFF: begin
        if (sts.off_fail || (sts.ext_en && sts.ext_short)) begin
          cmd.emit_status = 1'b1;
          cmd.code        = STS_MALFORMED;
        end else if (sts.ext_en) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_EXT_HI;
        end
      end
      S_EXT_HI: begin
        cmd.ext_hi_ld = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RA_EXT_LO;
      end
      S_EXT_LO: begin
        if (sts.ext_fail) begin
          cmd.emit_status = 1'b1;
          cmd.code        = STS_MALFORMED;
        end else begin
          cmd.ext_ld = 1'b1;
        end
      end
      S_CHK_PLD: begin
        if (sts.pld_empty) begin
          cmd.emit_status = 1'b1;
          cmd.code        = STS_MALFORMED;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_NAL;
        end
      end
      S_NAL: begin
        cmd.nal_ld = 1'b1;
        if (sts.nal_single) begin
          cmd.single_acc  = 1'b1;
          cmd.emit_status = 1'b1;
          cmd.code        = STS_READY;
        end else if (sts.nal_fu) begin
          if (sts.fu_short) begin
            cmd.emit_status = 1'b1;
            cmd.code        = STS_MALFORMED;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_FU;
          end
        end else if (sts.nal_agg) begin
          cmd.emit_status = 1'b1;
          cmd.code        = STS_AGGREGATION;
        end else begin
          cmd.emit_status = 1'b1;
          cmd.code        = STS_UNKNOWN_TYPE;
        end
      end
      S_FU: begin
        cmd.fu_acc      = 1'b1;
        cmd.emit_status = 1'b1;
        cmd.code        = STS_READY;
      end
      S_DRAIN: begin
        cmd.drain_emit = 1'b1;
      end
      default: begin
        cmd.code = STS_READY;
      end
    endcase
  end

  // assertions
  `RTPD_ASSERT_IMPLY(a_drain_from_idle, clk, rst_n, state_r == S_DRAIN, $past(state_r) == S_IDLE, "drain read not issued from idle")
  `RTPD_ASSERT_IMPLY(a_status_only_busy, clk, rst_n, cmd.emit_status, state_r != S_IDLE, "status beat issued while idle")

endmodule

`default_nettype wire

/* rtl/rtpd_dp.sv */
// datapath: packet buffer, header parse registers and stream output
`default_nettype none

`include "rtp_h264_depacketizer_macros.svh"

module rtpd_dp #(
  parameter int PACKET_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_data_byte,
  input  rtpd_pkg::rtpd_cmd_t  cmd,
  output rtpd_pkg::rtpd_sts_t  sts,
  output logic                 out_valid,
  output logic                 out_is_status,
  output logic [2:0]           out_status,
  output logic [7:0]           out_out_byte,
  output logic                 out_end_of_unit
);

  import rtpd_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int SW = ((CW > 18) ? CW : 18) + 1;

  // control registers
  logic [CW-1:0] wc_r, wc_nxt;
  logic          ovf_r, ovf_nxt;
  logic          drain_r, drain_nxt;
  logic [2:0]    prefix_r, prefix_nxt;
  logic          ov_r, ov_nxt;

  // payload registers
  logic          pkt_ovf_r, pkt_ovf_nxt;
  logic [7:0]    hdr_r, hdr_nxt;
  logic [7:0]    pad_r, pad_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic [CW-1:0] rp_r, rp_nxt;
  logic [7:0]    ext_hi_r, ext_hi_nxt;
  logic [7:0]    nal_r, nal_nxt;
  logic [7:0]    fu_r, fu_nxt;
  logic          ois_r, ois_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          oe_r, oe_nxt;

  // buffer port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ra_full;
  logic [7:0]    rd_data;

  // helpers
  logic          wc_lt;
  logic          fu_start;
  logic [7:0]    nal_hdr;
  logic          rp_lt_end;
  logic [4:0]    nal_type;
  logic [SW-1:0] len_x, off_x, ext_sum;
  logic [CW-1:0] off_fu;
  logic [7:0]    pfx_byte;
  logic [2:0]    pfx_nxt;
  logic          pfx_eou;
  status_t       hdr_code;

  assign wc_lt     = wc_r < CW'(PACKET_BYTES);
  assign fu_start  = (nal_r[4:0] == NAL_TYPE_FU_A);
  assign nal_hdr   = {nal_r[7:5], fu_r[4:0]};
  assign rp_lt_end = rp_r < len_r;
  assign nal_type  = rd_data[4:0];
  assign len_x     = SW'(len_r);
  assign off_x     = SW'(off_r);
  assign ext_sum   = off_x + SW'(EXT_HDR_BYTES) + SW'({ext_hi_r, rd_data, 2'b00});
  assign off_fu    = off_r + CW'(FU_HDR_BYTES);
  assign ram_waddr = wc_r[AW-1:0];
  assign ram_raddr = ra_full[AW-1:0];

  // read address select; extension length sits two bytes into its header
  always_comb begin
    unique case (cmd.rd_sel)
      RA_PTR:    ra_full = rp_r;
      RA_NAL:    ra_full = off_r;
      RA_FU:     ra_full = off_r + CW'(1);
      RA_EXT_HI: ra_full = off_r + CW'(2);
      RA_EXT_LO: ra_full = off_r + CW'(3);
      default:   ra_full = rp_r;
    endcase
  end

  // fixed header checks, in priority order
  always_comb begin
    if (pkt_ovf_r) begin
      hdr_code = STS_OVERSIZE;
    end else if (len_x < SW'(RTP_FIXED_HDR)) begin
      hdr_code = STS_MALFORMED;
    end else if (hdr_r[7:6] != RTP_VERSION) begin
      hdr_code = STS_BAD_VERSION;
    end else if (hdr_r[5] && (SW'(pad_r) + SW'(RTP_FIXED_HDR) > len_x)) begin
      hdr_code = STS_MALFORMED;
    end else begin
      hdr_code = STS_READY;
    end
  end

  // start code sequencer: three zeros, a one, then for an fu-a fragment the rebuilt header
  always_comb begin
    case (prefix_r)
      PFX_ONE: begin
        pfx_byte = 8'h01;
        pfx_nxt  = fu_start ? PFX_NAL_HDR : PFX_NONE;
      end
      PFX_NAL_HDR: begin
        pfx_byte = nal_hdr;
        pfx_nxt  = PFX_NONE;
      end
      default: begin
        pfx_byte = 8'h00;
        pfx_nxt  = prefix_r + 3'd1;
      end
    endcase
    pfx_eou = (pfx_nxt == PFX_NONE) && !rp_lt_end;
  end

  // status to controller
  always_comb begin
    sts.drain_pending = drain_r;
    sts.prefix_nz     = (prefix_r != PFX_NONE);
    sts.rp_lt_end     = rp_lt_end;
    sts.hdr_code      = hdr_code;
    sts.off_fail      = len_r < off_r;
    sts.ext_en        = hdr_r[4];
    sts.ext_short     = len_x < off_x + SW'(EXT_HDR_BYTES);
    sts.ext_fail      = len_x < ext_sum;
    sts.pld_empty     = len_r <= off_r;
    sts.nal_single    = (nal_type != 5'd0) && (nal_type <= NAL_TYPE_SINGLE_MAX);
    sts.nal_fu        = (nal_type == NAL_TYPE_FU_A);
    sts.nal_agg       = (nal_type == NAL_TYPE_STAP_A);
    sts.fu_short      = len_x < off_x + SW'(FU_HDR_BYTES);
  end

  // register updates per command
  always_comb begin
    wc_nxt      = wc_r;
    ovf_nxt     = ovf_r;
    drain_nxt   = drain_r;
    prefix_nxt  = prefix_r;
    ov_nxt      = 1'b0;
    pkt_ovf_nxt = pkt_ovf_r;
    hdr_nxt     = hdr_r;
    pad_nxt     = pad_r;
    len_nxt     = len_r;
    off_nxt     = off_r;
    rp_nxt      = rp_r;
    ext_hi_nxt  = ext_hi_r;
    nal_nxt     = nal_r;
    fu_nxt      = fu_r;
    ois_nxt     = ois_r;
    ost_nxt     = ost_r;
    ob_nxt      = ob_r;
    oe_nxt      = oe_r;
    ram_we      = 1'b0;

    // packet byte beat; cancels any drain in progress
    if (cmd.wr_byte) begin
      drain_nxt  = 1'b0;
      prefix_nxt = PFX_NONE;
      if (wc_r == '0) begin
        hdr_nxt = in_data_byte;
      end
      if (wc_lt) begin
        ram_we = 1'b1;
        wc_nxt = wc_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (cmd.wr_last) begin
        len_nxt     = wc_lt ? (wc_r + CW'(1)) : wc_r;
        pkt_ovf_nxt = ovf_r | !wc_lt;
        pad_nxt     = in_data_byte;
        wc_nxt      = '0;
        ovf_nxt     = 1'b0;
      end
    end

    // strip padding, set offset past the csrc list
    if (cmd.chk_hdr) begin
      if (hdr_r[5]) begin
        len_nxt = len_r - CW'(pad_r);
      end
      off_nxt = CW'(RTP_FIXED_HDR) + CW'({hdr_r[3:0], 2'b00});
    end

    // extension header
    if (cmd.ext_hi_ld) begin
      ext_hi_nxt = rd_data;
    end
    if (cmd.ext_ld) begin
      off_nxt = ext_sum[CW-1:0];
    end

    // nal classification results
    if (cmd.nal_ld) begin
      nal_nxt = rd_data;
    end
    if (cmd.single_acc) begin
      rp_nxt     = off_r;
      prefix_nxt = PFX_FIRST;
      drain_nxt  = 1'b1;
    end
    if (cmd.fu_acc) begin
      fu_nxt     = rd_data;
      rp_nxt     = off_fu;
      prefix_nxt = rd_data[7] ? PFX_FIRST : PFX_NONE;
      drain_nxt  = rd_data[7] || (off_fu < len_r);
    end

    // drain: start code bytes come straight from the sequencer
    if (cmd.drain_prefix) begin
      ov_nxt     = 1'b1;
      ois_nxt    = 1'b0;
      ost_nxt    = STS_READY;
      ob_nxt     = pfx_byte;
      oe_nxt     = pfx_eou;
      prefix_nxt = pfx_nxt;
      if (pfx_eou) begin
        drain_nxt = 1'b0;
      end
    end
    if (cmd.drain_issue) begin
      rp_nxt = rp_r + CW'(1);
    end
    if (cmd.drain_emit) begin
      ov_nxt  = 1'b1;
      ois_nxt = 1'b0;
      ost_nxt = STS_READY;
      ob_nxt  = rd_data;
      oe_nxt  = !rp_lt_end;
      if (!rp_lt_end) begin
        drain_nxt = 1'b0;
      end
    end
    if (cmd.drain_stop) begin
      drain_nxt = 1'b0;
    end

    // per-packet status beat
    if (cmd.emit_status) begin
      ov_nxt  = 1'b1;
      ois_nxt = 1'b1;
      ost_nxt = cmd.code;
      ob_nxt  = 8'h00;
      oe_nxt  = 1'b0;
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r     <= '0;
      ovf_r    <= 1'b0;
      drain_r  <= 1'b0;
      prefix_r <= PFX_NONE;
      ov_r     <= 1'b0;
    end else begin
      wc_r     <= wc_nxt;
      ovf_r    <= ovf_nxt;
      drain_r  <= drain_nxt;
      prefix_r <= prefix_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pkt_ovf_r <= pkt_ovf_nxt;
    hdr_r     <= hdr_nxt;
    pad_r     <= pad_nxt;
    len_r     <= len_nxt;
    off_r     <= off_nxt;
    rp_r      <= rp_nxt;
    ext_hi_r  <= ext_hi_nxt;
    nal_r     <= nal_nxt;
    fu_r      <= fu_nxt;
    ois_r     <= ois_nxt;
    ost_r     <= ost_nxt;
    ob_r      <= ob_nxt;
    oe_r      <= oe_nxt;
  end

  // packet buffer
  rtpd_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_byte),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign out_valid       = ov_r;
  assign out_is_status   = ois_r;
  assign out_status      = ost_r;
  assign out_out_byte    = ob_r;
  assign out_end_of_unit = oe_r;

  // assertions
  `RTPD_ASSERT_IMPLY(a_ptr_in_range, clk, rst_n, drain_r, rp_r <= len_r, "read pointer past payload end")
  `RTPD_ASSERT_IMPLY(a_prefix_needs_drain, clk, rst_n, prefix_r != PFX_NONE, drain_r, "start code pending without drain")

endmodule

`default_nettype wire

/* sim/rtp_h264_depacketizer_test.sv */
// self-checking testbench for the rtp h.264 depacketizer: directed and random packet streams
`default_nettype none

module rtp_h264_depacketizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpd_pkg::*;

  localparam int   PKT_BYTES   = 4096;
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_DRAIN   = 1'b1;
  localparam int   RAND_BEATS  = 570;
  localparam int   DRAIN_WAIT  = 2000;
  localparam int   TAIL_CYCLES = 16;
  localparam int   PRINT_CAP   = 100;

  // one output beat as the block presents it
  typedef struct packed {
    logic       is_st;
    logic [2:0] st;
    logic [7:0] ob;
    logic       eou;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       in_cmd = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  wire        busy;
  wire        out_valid;
  wire        out_is_status;
  wire  [2:0] out_status;
  wire  [7:0] out_out_byte;
  wire        out_end_of_unit;

  rtp_h264_depacketizer #(
    .PACKET_BYTES(PKT_BYTES)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_is_status  (out_is_status),
    .out_status     (out_status),
    .out_out_byte   (out_out_byte),
    .out_end_of_unit(out_end_of_unit)
  );

  always #6 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // depacketizer state mirrored by the predictor
  logic [7:0]  pkt_mem [0:PKT_BYTES-1];
  int unsigned wr_cnt;
  int unsigned rd_ptr;
  int unsigned pld_end;
  int unsigned pld_start;
  logic [7:0]  hdr_flags;
  logic [15:0] ext_words;
  logic [7:0]  nal_hdr;
  logic [7:0]  fu_hdr;
  logic [2:0]  pfx_step;
  bit          drain_on;
  bit          ovf;

  out_beat_t   due_out[$];
  logic [7:0]  pkt_buf[$];
  int          err_cnt = 0;
  int          beats_sent = 0;
  int          gap_pct = 0;

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
  endtask

  function automatic void clear_depack_state();
    wr_cnt    = 0;
    rd_ptr    = 0;
    pld_end   = 0;
    pld_start = 0;
    hdr_flags = 8'h00;
    ext_words = 16'h0000;
    nal_hdr   = 8'h00;
    fu_hdr    = 8'h00;
    pfx_step  = PFX_NONE;
    drain_on  = 1'b0;
    ovf       = 1'b0;
  endfunction

  // header parse and nal classification of a finished packet
  function automatic status_t classify_rtp(input int unsigned len);
    int unsigned off;
    int unsigned pad;
    int unsigned avail;
    logic [4:0]  ntype;
    if (len < RTP_FIXED_HDR) return STS_MALFORMED;
    if (hdr_flags[7:6] != RTP_VERSION) return STS_BAD_VERSION;
    // padding count sits in the final byte
    if (hdr_flags[5]) begin
      pad = pkt_mem[len - 1];
      if (pad + RTP_FIXED_HDR > len) return STS_MALFORMED;
      len -= pad;
    end
    off = RTP_FIXED_HDR + 4 * hdr_flags[3:0];
    if (len < off) return STS_MALFORMED;
    // extension header: length in 32-bit words at offset 2
    if (hdr_flags[4]) begin
      if (len < off + EXT_HDR_BYTES) return STS_MALFORMED;
      ext_words = {pkt_mem[off + 2], pkt_mem[off + 3]};
      if (len < off + EXT_HDR_BYTES + 4 * ext_words) return STS_MALFORMED;
      off += EXT_HDR_BYTES + 4 * ext_words;
    end
    if (len <= off) return STS_MALFORMED;
    avail   = len - off;
    nal_hdr = pkt_mem[off];
    ntype   = nal_hdr[4:0];
    if (ntype != 5'd0 && ntype <= NAL_TYPE_SINGLE_MAX) begin
      pld_start = off;
      pfx_step  = PFX_FIRST;
    end else if (ntype == NAL_TYPE_FU_A) begin
      if (avail < FU_HDR_BYTES) return STS_MALFORMED;
      fu_hdr    = pkt_mem[off + 1];
      pld_start = off + FU_HDR_BYTES;
      pfx_step  = fu_hdr[7] ? PFX_FIRST : PFX_NONE;
    end else if (ntype == NAL_TYPE_STAP_A) begin
      return STS_AGGREGATION;
    end else begin
      return STS_UNKNOWN_TYPE;
    end
    pld_end  = len;
    rd_ptr   = pld_start;
    drain_on = (pfx_step != PFX_NONE) || (rd_ptr < pld_end);
    return STS_READY;
  endfunction

  // advance the predictor by one accepted beat, queue what it produces
  function automatic void depack_beat(input logic cmd, input logic [7:0] b, input logic last);
    status_t   st;
    out_beat_t r;
    bit        fu_frag;
    r = '0;
    if (cmd == CMD_WRITE) begin
      drain_on = 1'b0;
      pfx_step = PFX_NONE;
      if (wr_cnt == 0) hdr_flags = b;
      if (wr_cnt < PKT_BYTES) begin
        pkt_mem[wr_cnt] = b;
        wr_cnt++;
      end else begin
        ovf = 1'b1;
      end
      if (!last) return;
      st = ovf ? STS_OVERSIZE : classify_rtp(wr_cnt);
      if (st != STS_READY) begin
        drain_on = 1'b0;
        pfx_step = PFX_NONE;
      end
      wr_cnt  = 0;
      ovf     = 1'b0;
      r.is_st = 1'b1;
      r.st    = st;
      due_out.push_back(r);
    end else begin
      fu_frag = (nal_hdr[4:0] == NAL_TYPE_FU_A);
      if (!drain_on) return;
      // start code, then rebuilt header for a starting fragment, then payload
      if (pfx_step != PFX_NONE) begin
        if (pfx_step < PFX_ONE) begin
          r.ob = 8'h00;
          pfx_step++;
        end else if (pfx_step == PFX_ONE) begin
          r.ob = 8'h01;
          pfx_step = fu_frag ? PFX_NAL_HDR : PFX_NONE;
        end else begin
          r.ob = {nal_hdr[7:5], fu_hdr[4:0]};
          pfx_step = PFX_NONE;
        end
      end else if (rd_ptr < pld_end) begin
        r.ob = pkt_mem[rd_ptr];
        rd_ptr++;
      end else begin
        drain_on = 1'b0;
        return;
      end
      if (pfx_step == PFX_NONE && rd_ptr >= pld_end) begin
        drain_on = 1'b0;
        r.eou    = 1'b1;
      end
      r.st = STS_READY;
      due_out.push_back(r);
    end
  endfunction

  // stream bytes still owed by the pending drain
  function automatic int unsigned bytes_owed();
    int unsigned n;
    n = 0;
    if (drain_on) begin
      if (pfx_step != PFX_NONE) begin
        n = ((nal_hdr[4:0] == NAL_TYPE_FU_A) ? int'(PFX_NAL_HDR) : int'(PFX_ONE)) + 1 - pfx_step;
      end
      n += pld_end - rd_ptr;
    end
    return n;
  endfunction

  // compare every result beat with the oldest prediction
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid) begin
      if (due_out.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: is_status %0b status %0d byte %02h eou %0b",
                                  out_is_status, out_status, out_out_byte, out_end_of_unit));
      end else begin
        e = due_out.pop_front();
        if (out_is_status !== e.is_st)
          report_mismatch($sformatf("is_status %0b, want %0b", out_is_status, e.is_st));
        if (out_status !== e.st)
          report_mismatch($sformatf("status %0d, want %0d", out_status, e.st));
        if (out_out_byte !== e.ob)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_out_byte, e.ob));
        if (out_end_of_unit !== e.eou)
          report_mismatch($sformatf("end_of_unit %0b, want %0b", out_end_of_unit, e.eou));
      end
    end
  end

  // one input beat with random idle cycles ahead of it
  task automatic send_beat(input logic cmd, input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    depack_beat(cmd, b, last);
    beats_sent++;
    @(negedge clk);
  endtask

  // stop sending until every predicted beat has come back
  task automatic hold_until_flushed();
    start <= 1'b0;
    @(negedge clk);
    while (due_out.size() != 0) @(negedge clk);
  endtask

  // ver, csrc count, ext words (-1 none), pad bytes (0 none), nal and fu byte (-1 none)
  function automatic void build_packet(input logic [1:0] ver, input int csrc, input int ext_len,
                                       input int pad_len, input int nal, input int fu,
                                       input int body);
    pkt_buf.delete();
    pkt_buf.push_back({ver, pad_len > 0, ext_len >= 0, 4'(csrc)});
    repeat (RTP_FIXED_HDR - 1) pkt_buf.push_back(8'($urandom));
    repeat (4 * csrc) pkt_buf.push_back(8'($urandom));
    if (ext_len >= 0) begin
      repeat (2) pkt_buf.push_back(8'($urandom));
      pkt_buf.push_back(ext_len[15:8]);
      pkt_buf.push_back(ext_len[7:0]);
      repeat (4 * ext_len) pkt_buf.push_back(8'($urandom));
    end
    if (nal >= 0) pkt_buf.push_back(nal[7:0]);
    if (fu >= 0) pkt_buf.push_back(fu[7:0]);
    repeat (body) pkt_buf.push_back(8'($urandom));
    if (pad_len > 0) begin
      repeat (pad_len - 1) pkt_buf.push_back(8'($urandom));
      pkt_buf.push_back(8'(pad_len));
    end
  endfunction

  function automatic void cut_packet(input int n);
    while (pkt_buf.size() > n) void'(pkt_buf.pop_back());
  endfunction

  task automatic send_packet();
    for (int i = 0; i < pkt_buf.size(); i++) begin
      send_beat(CMD_WRITE, pkt_buf[i], i == pkt_buf.size() - 1);
    end
  endtask

  task automatic drain_ticks(input int n);
    repeat (n) send_beat(CMD_DRAIN, 8'($urandom), 1'($urandom));
  endtask

  task automatic flush_drain(input int extra);
    drain_ticks(bytes_owed() + extra);
  endtask

  // drain ticks with nothing pending
  task automatic test_idle_drain();
    drain_ticks(3);
  endtask

  // single nal units, smallest and widest header values
  task automatic test_single_nal();
    build_packet(RTP_VERSION, 0, -1, 0, 8'h01, -1, 0);
    send_packet();
    flush_drain(1);
    build_packet(RTP_VERSION, 0, -1, 0, 8'hF7, -1, 6);
    pkt_buf[13] = 8'h00;
    pkt_buf[14] = 8'hFF;
    send_packet();
    flush_drain(0);
  endtask

  // csrc list, extension header and padding skipped ahead of the payload
  task automatic test_header_skip();
    build_packet(RTP_VERSION, 15, 2, 5, 8'h65, -1, 4);
    send_packet();
    flush_drain(0);
    build_packet(RTP_VERSION, 1, 0, 0, 8'h41, -1, 2);
    send_packet();
    flush_drain(0);
    build_packet(RTP_VERSION, 0, -1, 255, 8'h21, -1, 3);
    send_packet();
    flush_drain(1);
  endtask

  // fu-a fragments: start, middle, end, empty ones and a short one
  task automatic test_fu_a();
    build_packet(RTP_VERSION, 0, -1, 0, 8'h7C, 8'h85, 5);
    send_packet();
    flush_drain(0);
    build_packet(RTP_VERSION, 0, -1, 0, 8'h7C, 8'h05, 3);
    send_packet();
    flush_drain(0);
    build_packet(RTP_VERSION, 0, -1, 0, 8'h7C, 8'h45, 2);
    send_packet();
    flush_drain(0);
    // starting fragment with no payload, every header bit set but the fu reserved bit
    build_packet(RTP_VERSION, 0, -1, 0, 8'hFC, 8'hDF, 0);
    send_packet();
    flush_drain(0);
    // continuation with no payload: ready, nothing to emit
    build_packet(RTP_VERSION, 0, -1, 0, 8'h1C, 8'h01, 0);
    send_packet();
    drain_ticks(1);
    // indicator without an fu header
    build_packet(RTP_VERSION, 0, -1, 0, 8'h1C, -1, 0);
    send_packet();
  endtask

  // packets dropped with a status beat
  task automatic test_drops();
    int unk[7];
    unk = '{0, 25, 26, 27, 29, 30, 31};
    build_packet(RTP_VERSION, 0, -1, 0, 8'h01, -1, 2);
    cut_packet(RTP_FIXED_HDR - 1);
    send_packet();
    build_packet(2'd0, 0, -1, 0, 8'h01, -1, 1);
    send_packet();
    build_packet(2'd1, 0, -1, 0, 8'h01, -1, 1);
    send_packet();
    build_packet(2'd3, 0, -1, 0, 8'h01, -1, 1);
    send_packet();
    build_packet(RTP_VERSION, 0, -1, 0, 8'h18, -1, 4);
    send_packet();
    foreach (unk[i]) begin
      build_packet(RTP_VERSION, 0, -1, 0, ($urandom_range(0, 7) << 5) | unk[i], -1, 2);
      send_packet();
    end
    // empty payload
    build_packet(RTP_VERSION, 0, -1, 0, -1, -1, 0);
    send_packet();
    // padding count larger than the packet
    build_packet(RTP_VERSION, 0, -1, 3, 8'h01, -1, 0);
    pkt_buf[pkt_buf.size() - 1] = 8'hFF;
    send_packet();
    // truncated csrc list
    build_packet(RTP_VERSION, 4, -1, 0, 8'h01, -1, 2);
    cut_packet(20);
    send_packet();
    // truncated extension header, then truncated extension body
    build_packet(RTP_VERSION, 0, 3, 0, 8'h01, -1, 2);
    cut_packet(14);
    send_packet();
    build_packet(RTP_VERSION, 0, 3, 0, 8'h01, -1, 2);
    cut_packet(20);
    send_packet();
    drain_ticks(1);
  endtask

  // a new packet cancels the rest of a drain
  task automatic test_write_during_drain();
    build_packet(RTP_VERSION, 0, -1, 0, 8'h01, -1, 8);
    send_packet();
    drain_ticks(3);
    build_packet(RTP_VERSION, 0, -1, 0, 8'h7C, 8'h81, 6);
    send_packet();
    drain_ticks(7);
    build_packet(RTP_VERSION, 0, -1, 0, 8'h05, -1, 3);
    send_packet();
    flush_drain(0);
  endtask

  // full buffer, one byte too many, then normal operation
  task automatic test_size_limits();
    build_packet(RTP_VERSION, 0, -1, 0, 8'h01, -1, PKT_BYTES - RTP_FIXED_HDR - 1);
    send_packet();
    flush_drain(0);
    build_packet(RTP_VERSION, 0, -1, 0, 8'h01, -1, PKT_BYTES - RTP_FIXED_HDR);
    send_packet();
    drain_ticks(1);
    build_packet(RTP_VERSION, 0, -1, 0, 8'h09, -1, 4);
    send_packet();
    flush_drain(0);
  endtask

  // one random packet with its drain; mostly well formed, some broken or noise
  task automatic random_round();
    int csrc;
    int ext_len;
    int pad_len;
    int nal;
    int fu;
    int body;
    int ty;
    int pick;
    int n;
    csrc    = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) : 0;
    ext_len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : -1;
    pad_len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
    body    = $urandom_range(0, 20);
    pick    = $urandom_range(0, 99);
    if (pick < 55) begin
      ty = $urandom_range(1, NAL_TYPE_SINGLE_MAX);
    end else if (pick < 88) begin
      ty = NAL_TYPE_FU_A;
    end else if (pick < 93) begin
      ty = NAL_TYPE_STAP_A;
    end else begin
      n  = $urandom_range(0, 6);
      ty = (n == 0) ? 0 : (n <= 3) ? NAL_TYPE_STAP_A + n : NAL_TYPE_FU_A + n - 3;
    end
    nal = ($urandom_range(0, 7) << 5) | ty;
    fu  = (ty == NAL_TYPE_FU_A) ? int'($urandom_range(0, 255)) : -1;
    if (ty == NAL_TYPE_FU_A && $urandom_range(0, 15) == 0) begin
      fu   = -1;
      body = 0;
    end
    build_packet(RTP_VERSION, csrc, ext_len, pad_len, nal, fu, body);
    // damage about one packet in five
    if ($urandom_range(0, 99) >= 80) begin
      case ($urandom_range(0, 3))
        0: cut_packet($urandom_range(1, pkt_buf.size()));
        1: pkt_buf[0] = (pkt_buf[0] & 8'h3F) | 8'($urandom_range(0, 3) << 6);
        2: begin
          // padding flag with a random count byte
          pkt_buf[0] = pkt_buf[0] | 8'h20;
          pkt_buf[pkt_buf.size() - 1] = 8'($urandom);
        end
        default: begin
          pkt_buf.delete();
          repeat ($urandom_range(1, 40)) pkt_buf.push_back(8'($urandom));
        end
      endcase
    end
    send_packet();
    if ($urandom_range(0, 99) < 80) flush_drain($urandom_range(0, 2));
    else drain_ticks($urandom_range(0, bytes_owed()));
    if ($urandom_range(0, 24) == 0) hold_until_flushed();
  endtask

  task automatic test_random(input int pct);
    int stop_at;
    gap_pct = pct;
    stop_at = beats_sent + RAND_BEATS;
    while (beats_sent < stop_at) random_round();
    hold_until_flushed();
  endtask

  // test sequence
  initial begin
    int wait_cyc;
    clear_depack_state();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_drain();
    test_single_nal();
    test_header_skip();
    test_fu_a();
    test_drops();
    test_write_during_drain();
    test_size_limits();
    hold_until_flushed();
    test_random(0);
    test_random(86);
    test_random(12);
    // wait out the last beats, then a few quiet cycles
    start <= 1'b0;
    @(negedge clk);
    for (wait_cyc = 0; due_out.size() != 0 && wait_cyc < DRAIN_WAIT; wait_cyc++) @(negedge clk);
    if (due_out.size() != 0) report_mismatch($sformatf("%0d beats never came", due_out.size()));
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
